[hw/rtl/grdjs_pkg.sv]
// ----------------------------------------------------------------------------
// grdjs_pkg
// Shared types and constants for the release-day job scheduler.
// ----------------------------------------------------------------------------
package grdjs_pkg;

    localparam int JOB_CAPACITY_DEF = 1024;
    localparam int DAY_W            = 16;
    localparam int REWARD_W         = 16;
    localparam int TOTAL_W          = 26;
    localparam logic [DAY_W-1:0] DAYS_TOTAL_RST = 16'd1;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_RUN_INIT,
        OP_SCAN_RD,
        OP_SCAN_CHK,
        OP_SCAN_NEXT,
        OP_PUSH_RD,
        OP_PUSH_ROOT,
        OP_PUSH_MOVE,
        OP_TOP_RD,
        OP_TOP_TAKE,
        OP_LAST_RD,
        OP_LAST_TAKE,
        OP_C1_RD,
        OP_C1_TAKE,
        OP_C2_RD,
        OP_C2_TAKE,
        OP_SIFT_PLACE,
        OP_SIFT_MOVE,
        OP_DAY_INC,
        OP_FINISH
    } op_t;

    typedef struct packed {
        op_t  op;
        logic in_ready;
    } cmd_t;

    typedef struct packed {
        logic eligible;
        logic scan_last;
        logic cnt_zero;
        logic i_zero;
        logic parent_ge;
        logic q_zero;
        logic q_one;
        logic c_out;
        logic c1_out;
        logic best_le;
        logic day_last;
        logic days_zero;
        logic later_jobs;
        logic out_busy;
    } status_t;

endpackage

[hw/rtl/grdjs_dpath.sv]
// ----------------------------------------------------------------------------
// grdjs_dpath
// Job store, heap memory, day/scan counters, running total and output register.
// ----------------------------------------------------------------------------
module grdjs_dpath
    import grdjs_pkg::*;
#(
    parameter int JOB_CAPACITY = JOB_CAPACITY_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output status_t             status,
    input  logic [DAY_W-1:0]    in_release_day,
    input  logic [REWARD_W-1:0] in_reward,
    input  logic                cfg_write,
    input  logic [DAY_W-1:0]    cfg_days,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [TOTAL_W-1:0]  out_total,
    output logic                out_dropped
);

    localparam int AW = (JOB_CAPACITY > 1) ? $clog2(JOB_CAPACITY) : 1;
    localparam int CW = $clog2(JOB_CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(JOB_CAPACITY);

    logic [DAY_W-1:0]    rel_mem [JOB_CAPACITY];
    logic [REWARD_W-1:0] rew_mem [JOB_CAPACITY];
    logic [REWARD_W-1:0] heap_mem [JOB_CAPACITY];

    logic [DAY_W-1:0]    days_total_reg;
    logic [CW-1:0]       job_cnt_reg;
    logic                ovf_reg;
    logic [CW-1:0]       qsize_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic                out_valid_reg;
    logic [TOTAL_W-1:0]  out_total_reg;
    logic                out_dropped_reg;
    logic [DAY_W-1:0]    day_reg;
    logic [AW-1:0]       scan_reg;
    logic                hi_reg;
    logic [AW-1:0]       i_reg;
    logic [REWARD_W-1:0] v_reg;
    logic [REWARD_W-1:0] best_reg;
    logic [AW-1:0]       bidx_reg;
    logic [DAY_W-1:0]    rel_rd_reg;
    logic [REWARD_W-1:0] rew_rd_reg;
    logic [REWARD_W-1:0] heap_rd_reg;

    logic [AW-1:0]       parent;
    logic [AW+1:0]       c_ext;
    logic [AW+1:0]       c1_ext;
    logic [AW+1:0]       q_ext;
    logic [CW-1:0]       scan_inc;
    logic [TOTAL_W:0]    sum_ext;
    logic                heap_we;
    logic [AW-1:0]       heap_wa;
    logic [REWARD_W-1:0] heap_wd;
    logic                heap_re;
    logic [AW-1:0]       heap_ra;

    assign parent   = AW'((i_reg - AW'(1)) >> 1);
    assign c_ext    = {1'b0, i_reg, 1'b1};
    assign c1_ext   = c_ext + (AW+2)'(1);
    assign q_ext    = (AW+2)'(qsize_reg);
    assign scan_inc = CW'(scan_reg) + CW'(1);
    assign sum_ext  = {1'b0, total_reg} + (TOTAL_W+1)'(heap_rd_reg);

    always_comb
    begin
        status.eligible   = (rel_rd_reg == day_reg) ||
                            ((day_reg == DAY_W'(1)) && (rel_rd_reg == '0));
        status.scan_last  = (scan_inc == job_cnt_reg);
        status.cnt_zero   = (job_cnt_reg == '0);
        status.i_zero     = (i_reg == '0);
        status.parent_ge  = (heap_rd_reg >= v_reg);
        status.q_zero     = (qsize_reg == '0);
        status.q_one      = (qsize_reg == CW'(1));
        status.c_out      = (c_ext >= q_ext);
        status.c1_out     = (c1_ext >= q_ext);
        status.best_le    = (best_reg <= v_reg);
        status.day_last   = (day_reg == days_total_reg);
        status.days_zero  = (days_total_reg == '0);
        status.later_jobs = hi_reg;
        status.out_busy   = out_valid_reg && !out_ready;
    end

    always_comb
    begin
        heap_we = 1'b0;
        heap_wa = i_reg;
        heap_wd = v_reg;
        heap_re = 1'b0;
        heap_ra = '0;
        case (cmd.op)
            OP_PUSH_ROOT:  heap_we = 1'b1;
            OP_SIFT_PLACE: heap_we = 1'b1;
            OP_PUSH_MOVE:
            begin
                heap_we = 1'b1;
                heap_wd = heap_rd_reg;
            end
            OP_SIFT_MOVE:
            begin
                heap_we = 1'b1;
                heap_wd = best_reg;
            end
            OP_PUSH_RD:
            begin
                heap_re = 1'b1;
                heap_ra = parent;
            end
            OP_TOP_RD:  heap_re = 1'b1;
            OP_LAST_RD:
            begin
                heap_re = 1'b1;
                heap_ra = qsize_reg[AW-1:0];
            end
            OP_C1_RD:
            begin
                heap_re = 1'b1;
                heap_ra = c_ext[AW-1:0];
            end
            OP_C2_RD:
            begin
                heap_re = 1'b1;
                heap_ra = c1_ext[AW-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD && job_cnt_reg < CAP_C)
        begin
            rel_mem[job_cnt_reg[AW-1:0]] <= in_release_day;
            rew_mem[job_cnt_reg[AW-1:0]] <= in_reward;
        end
        if (cmd.op == OP_SCAN_RD)
        begin
            rel_rd_reg <= rel_mem[scan_reg];
            rew_rd_reg <= rew_mem[scan_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (heap_we)
            heap_mem[heap_wa] <= heap_wd;
        if (heap_re)
            heap_rd_reg <= heap_mem[heap_ra];
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_RUN_INIT:
            begin
                day_reg  <= DAY_W'(1);
                scan_reg <= '0;
                hi_reg   <= 1'b0;
            end
            OP_SCAN_CHK:
            begin
                if (rel_rd_reg > day_reg)
                    hi_reg <= 1'b1;
                if (status.eligible)
                begin
                    v_reg <= rew_rd_reg;
                    i_reg <= qsize_reg[AW-1:0];
                end
            end
            OP_SCAN_NEXT: scan_reg <= scan_reg + AW'(1);
            OP_PUSH_MOVE: i_reg <= parent;
            OP_LAST_TAKE:
            begin
                v_reg <= heap_rd_reg;
                i_reg <= '0;
            end
            OP_C1_TAKE:
            begin
                best_reg <= heap_rd_reg;
                bidx_reg <= c_ext[AW-1:0];
            end
            OP_C2_TAKE:
            begin
                if (heap_rd_reg > best_reg)
                begin
                    best_reg <= heap_rd_reg;
                    bidx_reg <= c1_ext[AW-1:0];
                end
            end
            OP_SIFT_MOVE: i_reg <= bidx_reg;
            OP_DAY_INC:
            begin
                day_reg  <= day_reg + DAY_W'(1);
                scan_reg <= '0;
                hi_reg   <= 1'b0;
            end
            OP_FINISH:
            begin
                out_total_reg   <= total_reg;
                out_dropped_reg <= ovf_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            days_total_reg <= DAYS_TOTAL_RST;
            job_cnt_reg    <= '0;
            ovf_reg        <= 1'b0;
            qsize_reg      <= '0;
            total_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                days_total_reg <= cfg_days;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (cmd.op)
                OP_LOAD:
                begin
                    if (job_cnt_reg < CAP_C)
                        job_cnt_reg <= job_cnt_reg + CW'(1);
                    else
                        ovf_reg <= 1'b1;
                end
                OP_RUN_INIT:
                begin
                    qsize_reg <= '0;
                    total_reg <= '0;
                end
                OP_SCAN_CHK:
                begin
                    if (status.eligible)
                        qsize_reg <= qsize_reg + CW'(1);
                end
                OP_TOP_TAKE:
                begin
                    qsize_reg <= qsize_reg - CW'(1);
                    total_reg <= sum_ext[TOTAL_W] ? '1 : sum_ext[TOTAL_W-1:0];
                end
                OP_FINISH:
                begin
                    out_valid_reg <= 1'b1;
                    job_cnt_reg   <= '0;
                    ovf_reg       <= 1'b0;
                    qsize_reg     <= '0;
                    total_reg     <= '0;
                end
                default: ;
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_total   = out_total_reg;
    assign out_dropped = out_dropped_reg;

    a_qsize_bound: assert property (@(posedge clk) disable iff (!rst_n)
        qsize_reg <= job_cnt_reg)
        else $error("heap larger than job store");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_TOP_TAKE) |-> (qsize_reg != '0))
        else $error("pop from empty heap");
    a_finish_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_FINISH) |=> (job_cnt_reg == '0 && !ovf_reg && out_valid_reg))
        else $error("set state not cleared after result");

endmodule

[hw/rtl/grdjs_ctrl.sv]
// ----------------------------------------------------------------------------
// grdjs_ctrl
// Sequencer for job loading, daily scan, heap push/pop and result handoff.
// ----------------------------------------------------------------------------
module grdjs_ctrl
    import grdjs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    in_last,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_START, S_DAY, S_SCAN_CHK, S_PUSH, S_PUSH_CMP, S_NEXT_JOB,
        S_DAY_END, S_TOP, S_LAST_RD, S_LAST, S_SIFT, S_C1, S_C2_RD, S_C2,
        S_CMP, S_NEXT_DAY, S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd.op       = OP_NONE;
        cmd.in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = OP_LOAD;
                    if (in_last)
                        state_next = S_START;
                end
            end
            S_START:
            begin
                cmd.op     = OP_RUN_INIT;
                state_next = status.days_zero ? S_FIN : S_DAY;
            end
            S_DAY:
            begin
                if (status.cnt_zero)
                    state_next = S_DAY_END;
                else
                begin
                    cmd.op     = OP_SCAN_RD;
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                cmd.op     = OP_SCAN_CHK;
                state_next = status.eligible ? S_PUSH : S_NEXT_JOB;
            end
            S_PUSH:
            begin
                if (status.i_zero)
                begin
                    cmd.op     = OP_PUSH_ROOT;
                    state_next = S_NEXT_JOB;
                end
                else
                begin
                    cmd.op     = OP_PUSH_RD;
                    state_next = S_PUSH_CMP;
                end
            end
            S_PUSH_CMP:
            begin
                if (status.parent_ge)
                begin
                    cmd.op     = OP_PUSH_ROOT;
                    state_next = S_NEXT_JOB;
                end
                else
                begin
                    cmd.op     = OP_PUSH_MOVE;
                    state_next = S_PUSH;
                end
            end
            S_NEXT_JOB:
            begin
                if (status.scan_last)
                    state_next = S_DAY_END;
                else
                begin
                    cmd.op     = OP_SCAN_NEXT;
                    state_next = S_DAY;
                end
            end
            S_DAY_END:
            begin
                if (status.q_zero)
                    state_next = status.later_jobs ? S_NEXT_DAY : S_FIN;
                else
                begin
                    cmd.op     = OP_TOP_RD;
                    state_next = S_TOP;
                end
            end
            S_TOP:
            begin
                cmd.op     = OP_TOP_TAKE;
                state_next = status.q_one ? S_NEXT_DAY : S_LAST_RD;
            end
            S_LAST_RD:
            begin
                cmd.op     = OP_LAST_RD;
                state_next = S_LAST;
            end
            S_LAST:
            begin
                cmd.op     = OP_LAST_TAKE;
                state_next = S_SIFT;
            end
            S_SIFT:
            begin
                if (status.c_out)
                begin
                    cmd.op     = OP_SIFT_PLACE;
                    state_next = S_NEXT_DAY;
                end
                else
                begin
                    cmd.op     = OP_C1_RD;
                    state_next = S_C1;
                end
            end
            S_C1:
            begin
                cmd.op     = OP_C1_TAKE;
                state_next = status.c1_out ? S_CMP : S_C2_RD;
            end
            S_C2_RD:
            begin
                cmd.op     = OP_C2_RD;
                state_next = S_C2;
            end
            S_C2:
            begin
                cmd.op     = OP_C2_TAKE;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (status.best_le)
                begin
                    cmd.op     = OP_SIFT_PLACE;
                    state_next = S_NEXT_DAY;
                end
                else
                begin
                    cmd.op     = OP_SIFT_MOVE;
                    state_next = S_SIFT;
                end
            end
            S_NEXT_DAY:
            begin
                if (status.day_last)
                    state_next = S_FIN;
                else
                begin
                    cmd.op     = OP_DAY_INC;
                    state_next = S_DAY;
                end
            end
            S_FIN:
            begin
                if (!status.out_busy)
                begin
                    cmd.op     = OP_FINISH;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[hw/rtl/greedy_release_day_job_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// greedy_release_day_job_scheduler_unit
// Greedy max-reward scheduler: stores jobs, then runs days with a binary heap.
// ----------------------------------------------------------------------------
// Loading: one job per cycle while idle. After the last job, each day scans every
// stored job, pushes each eligible reward up the heap past smaller parents and
// pops the top into the total, sifting the last entry down; after the last day
// the result goes to the output register. The next set loads while a result
// waits on the output register. Reset clears job count, heap size, total and
// overflow and valid flags; days_total resets to 1; no memory is cleared.
module greedy_release_day_job_scheduler_unit
    import grdjs_pkg::*;
#(
    parameter int JOB_CAPACITY = JOB_CAPACITY_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // release_day[15:0], reward[31:16]
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // total_reward[25:0], zero[31:26]
    output logic        m_tuser,   // jobs_dropped
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data   // days_total
);

    cmd_t               cmd;
    status_t            status;
    logic [TOTAL_W-1:0] total;

    grdjs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_last  (s_tlast),
        .status   (status),
        .cmd      (cmd)
    );

    grdjs_dpath #(
        .JOB_CAPACITY (JOB_CAPACITY)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .in_release_day (s_tdata[15:0]),
        .in_reward      (s_tdata[31:16]),
        .cfg_write      (cfg_valid),
        .cfg_days       (cfg_data),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_total      (total),
        .out_dropped    (m_tuser)
    );

    assign s_tready  = cmd.in_ready;
    assign cfg_ready = 1'b1;
    assign m_tdata   = {{(32-TOTAL_W){1'b0}}, total};

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// Testbench for greedy_release_day_job_scheduler_unit
// Sends job sets over the input stream and predicts each set's greedy total
// and drop flag. Covers the day-count register, capacity overflow, stalls on
// both sides and long output back-pressure.
// ----------------------------------------------------------------------------
module tb;
    import grdjs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY   = JOB_CAPACITY_DEF;
    localparam int LIMIT      = 6000000;
    localparam int SETTLE     = 40;

    typedef struct {
        logic [TOTAL_W-1:0] total;
        logic               dropped;
    } sched_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // release_day[15:0], reward[31:16]
    logic        s_tlast;   // last
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // total_reward[25:0], zero[31:26]
    logic        m_tuser;   // jobs_dropped
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;  // days_total

    // predictor state
    logic [DAY_W-1:0]    days_cfg;
    logic [DAY_W-1:0]    job_release_q[$];
    logic [REWARD_W-1:0] job_reward_q[$];
    logic                drop_seen;
    sched_result_t       pending_results[$];

    int  mismatches;
    int  cycles;
    bit  quiet;
    int  out_hold;

    greedy_release_day_job_scheduler_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic report(input string what, input int got, input int want);
        mismatches++;
        $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
    endtask

    // greedy: each day the largest released reward not yet taken
    function automatic sched_result_t schedule_set();
        sched_result_t r;
        int  pool[$];
        bit  queued[];
        int  n;
        int  day;
        int  best;
        int  next_rel;
        int  rel;
        longint sum;
        n = job_release_q.size();
        queued = new[n];
        sum = 0;
        day = 1;
        while (day <= int'(days_cfg))
        begin
            for (int i = 0; i < n; i++)
            begin
                rel = (job_release_q[i] == 0) ? 1 : int'(job_release_q[i]);
                if (!queued[i] && rel <= day)
                begin
                    queued[i] = 1'b1;
                    pool.push_back(job_reward_q[i]);
                end
            end
            if (pool.size() > 0)
            begin
                best = 0;
                foreach (pool[k])
                    if (pool[k] > pool[best])
                        best = k;
                sum += pool[best];
                pool.delete(best);
                day++;
            end
            else
            begin
                next_rel = -1;
                for (int i = 0; i < n; i++)
                    if (!queued[i] && (next_rel < 0 || job_release_q[i] < next_rel))
                        next_rel = job_release_q[i];
                if (next_rel < 0)
                    break;
                day = next_rel;
            end
        end
        r.total = (sum > 64'h3FFFFFF) ? '1 : sum[TOTAL_W-1:0];
        r.dropped = drop_seen;
        return r;
    endfunction

    task automatic release_input();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_job(input int rel, input int rew, input bit last);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rew[15:0], rel[15:0]};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (job_release_q.size() < CAPACITY)
        begin
            job_release_q.push_back(rel[15:0]);
            job_reward_q.push_back(rew[15:0]);
        end
        else
            drop_seen = 1'b1;
        if (last)
        begin
            pending_results.push_back(schedule_set());
            job_release_q.delete();
            job_reward_q.delete();
            drop_seen = 1'b0;
        end
    endtask

    task automatic drain();
        release_input();
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_days(input int v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v[15:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        days_cfg = v[15:0];
        @(posedge clk);
    endtask

    task automatic send_random_set(input int size, input int days);
        int rel;
        for (int i = 0; i < size; i++)
        begin
            rel = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(0, days + 2);
            send_job(rel, $urandom_range(0, 65535), i == size - 1);
        end
    endtask

    always @(posedge clk)
    begin
        sched_result_t e;
        if (m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report("unexpected result total", m_tdata[25:0], -1);
            else
            begin
                e = pending_results.pop_front();
                if (m_tdata[TOTAL_W-1:0] !== e.total)
                    report("total_reward", m_tdata[TOTAL_W-1:0], e.total);
                if (m_tuser !== e.dropped)
                    report("jobs_dropped", m_tuser, e.dropped);
            end
        end
    end

    initial
    begin
        int burst;
        burst = 0;
        forever
        begin
            @(posedge clk);
            if (out_hold > 0)
            begin
                out_hold--;
                m_tready <= 1'b0;
            end
            else
            begin
                if (!quiet && burst == 0 && $urandom_range(0, 7) == 0)
                    burst = $urandom_range(1, 10);
                if (burst > 0)
                begin
                    burst--;
                    m_tready <= 1'b0;
                end
                else
                    m_tready <= 1'b1;
            end
        end
    end

    task automatic test_directed();
        send_job(1, 500, 1'b1);             // reset day count of 1
        send_job(3, 9, 1'b0);
        send_job(1, 7, 1'b1);
        set_days(4);
        send_job(0, 65535, 1'b0);           // day zero acts as day one
        send_job(65535, 0, 1'b0);           // released after the last day
        send_job(1, 100, 1'b0);
        send_job(1, 100, 1'b0);             // equal rewards
        send_job(2, 300, 1'b0);
        send_job(4, 1, 1'b0);
        send_job(3, 32768, 1'b1);
        send_job(4, 12, 1'b1);              // idle days before first release
        send_job(5, 12, 1'b1);              // nothing ever released
        set_days(0);
        send_job(1, 65535, 1'b0);
        send_job(0, 4, 1'b1);
    endtask

    task automatic test_day_extremes();
        set_days(65535);
        send_job(65535, 65535, 1'b0);
        send_job(1, 1, 1'b1);
        set_days(1);
        send_job(1, 21845, 1'b0);
        send_job(1, 43690, 1'b1);
    endtask

    task automatic test_capacity();
        set_days(3);
        for (int i = 0; i < CAPACITY + 2; i++)
            send_job($urandom_range(0, 4), $urandom_range(0, 65535), i == CAPACITY + 1);
        send_job(2, 77, 1'b1);              // flag cleared for next set
    endtask

    task automatic test_random(input int sets);
        int days;
        for (int p = 0; p < sets / 8; p++)
        begin
            days = $urandom_range(1, 16);
            set_days(days);
            for (int s = 0; s < 8; s++)
                send_random_set($urandom_range(1, 8), days);
        end
    endtask

    task automatic test_backpressure();
        set_days(6);
        out_hold = 3000;
        for (int s = 0; s < 4; s++)
            send_random_set(5, 6);
        drain();                            // sender waits for every result
        send_random_set(5, 6);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        days_cfg  = DAYS_TOTAL_RST;
        drop_seen = 1'b0;
        mismatches = 0;
        quiet     = 1'b0;
        out_hold  = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_day_extremes();
        test_capacity();
        test_random(8);
        test_backpressure();
        quiet = 1'b1;
        test_random(8);
        drain();

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
